// ===== hw/rtl/bhdc_pkg.sv =====
// Shared types and constants for the header delta compressor.
// No dependencies; compiled first.
package bhdc_pkg;

  localparam int unsigned DEF_LIST_DEPTH   = 7;
  localparam int unsigned MAX_CODED_OFFSET = 7;
  localparam int unsigned CFG_IDX_W        = 8;

  localparam logic [31:0] RST_ALGO_MASK     = 32'h0000_0E00;
  localparam logic [31:0] RST_CODE_KAWPOW   = 32'h0000_0200;
  localparam logic [31:0] RST_CODE_EQ_WIDE  = 32'h0000_0400;
  localparam logic [31:0] RST_CODE_EQ_NARROW = 32'h0000_0600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALGO_MASK       = 8'd0,
    REG_CODE_KAWPOW     = 8'd1,
    REG_CODE_EQ_WIDE    = 8'd2,
    REG_CODE_EQ_NARROW  = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_FULL  = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0] version;
    logic [31:0] stamp;
    logic [31:0] target_bits;
    logic        has_previous;
    logic [31:0] prev_stamp;
    logic [31:0] prev_target_bits;
  } hdr_word_t;

  typedef struct packed {
    logic [2:0]         list_pos;
    logic               prev_hash_compressed;
    logic               time_compressed;
    logic signed [15:0] stamp_delta;
    logic               bits_compressed;
    logic               equihash_fields;
    logic               kawpow_fields;
  } res_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word, update list, load result register
    logic cfg_write;  // write config register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic list_full;
  } dp_status_t;

endpackage

// ===== hw/rtl/bhdc_ifs.sv =====
// Valid/ready channel interfaces: header input, result output, config write.
// No dependencies on other files.
interface bhdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] version;
  logic [31:0] stamp;
  logic [31:0] target_bits;
  logic        has_previous;
  logic [31:0] prev_stamp;
  logic [31:0] prev_target_bits;
  modport source (output valid, version, stamp, target_bits, has_previous, prev_stamp,
                  prev_target_bits, input ready);
  modport sink (input valid, version, stamp, target_bits, has_previous, prev_stamp,
                prev_target_bits, output ready);
endinterface

interface bhdc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         list_pos;
  logic               prev_hash_compressed;
  logic               time_compressed;
  logic signed [15:0] stamp_delta;
  logic               bits_compressed;
  logic               equihash_fields;
  logic               kawpow_fields;
  modport source (output valid, list_pos, prev_hash_compressed, time_compressed,
                  stamp_delta, bits_compressed, equihash_fields, kawpow_fields,
                  input ready);
  modport sink (input valid, list_pos, prev_hash_compressed, time_compressed,
                stamp_delta, bits_compressed, equihash_fields, kawpow_fields,
                output ready);
endinterface

interface bhdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/bhdc_ctrl.sv =====
// Controller: tracks the result register and issues load / config commands.
// Depends on bhdc_pkg.
module bhdc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  bhdc_pkg::dp_status_t   status,
  output bhdc_pkg::dp_cmd_t      cmd
);
  import bhdc_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.cfg_write = cfg_valid;
    cfg_ready     = 1'b1;
    case (state)
      ST_EMPTY: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_FULL;
        end
      end
      ST_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;  // result leaves as the next word enters
        if (in_valid && out_ready) begin
          cmd.load = 1'b1;
        end else if (out_ready) begin
          state_next = ST_EMPTY;
        end
      end
      default: state_next = ST_EMPTY;
    endcase
  end

`ifndef SYNTHESIS
  // a full list can only arise after at least one load
  a_full_needs_load: assert property (@(posedge clk) disable iff (rst)
    $rose(status.list_full) |-> $past(cmd.load))
    else $error("list filled without a load");
  // a load always leaves a result pending
  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_FULL)
    else $error("load did not leave result pending");
  // draining without a new load empties the result register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_FULL && out_ready && !cmd.load |=> state == ST_EMPTY)
    else $error("result register not released");
`endif

endmodule

// ===== hw/rtl/bhdc_datapath.sv =====
// Datapath: config registers, move-to-front version list, compare logic
// and the result register. Depends on bhdc_pkg.
module bhdc_datapath #(
  parameter int unsigned LIST_DEPTH = bhdc_pkg::DEF_LIST_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bhdc_pkg::dp_cmd_t                    cmd,
  output bhdc_pkg::dp_status_t                 status,
  input  bhdc_pkg::hdr_word_t                  hdr,
  input  logic [bhdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output bhdc_pkg::res_word_t                  res
);
  import bhdc_pkg::*;

  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic [31:0] algo_mask, code_kawpow, code_eq_wide, code_eq_narrow;
  logic [31:0] recent [LIST_DEPTH];
  logic [CW-1:0] count;

  logic [31:0]   masked;
  logic          kaw, equi;
  logic          hit;
  logic [IW-1:0] hit_pos;
  logic [IW-1:0] shift_lim;
  logic signed [32:0] diff;
  logic          fits;
  res_word_t     res_next;

  assign status.list_full = (count == CW'(LIST_DEPTH));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      algo_mask      <= RST_ALGO_MASK;
      code_kawpow    <= RST_CODE_KAWPOW;
      code_eq_wide   <= RST_CODE_EQ_WIDE;
      code_eq_narrow <= RST_CODE_EQ_NARROW;
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        REG_ALGO_MASK:      algo_mask      <= cfg_data;
        REG_CODE_KAWPOW:    code_kawpow    <= cfg_data;
        REG_CODE_EQ_WIDE:   code_eq_wide   <= cfg_data;
        REG_CODE_EQ_NARROW: code_eq_narrow <= cfg_data;
        default: ;
      endcase
    end
  end

  // algorithm flags; kawpow takes priority
  assign masked = hdr.version & algo_mask;
  assign kaw    = (masked == code_kawpow);
  assign equi   = !kaw && (masked == code_eq_wide || masked == code_eq_narrow);

  // parallel compare, first match nearest the front; only codable positions
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (i < MAX_CODED_OFFSET && CW'(i) < count && recent[i] == hdr.version) begin
        hit     = hdr.has_previous;
        hit_pos = IW'(i);
      end
    end
  end

  // entries below shift_lim move back one place; the entry at shift_lim is dropped
  assign shift_lim = hit ? hit_pos : IW'(LIST_DEPTH - 1);

  // exact signed difference, 33 bits
  assign diff = $signed({1'b0, hdr.stamp}) - $signed({1'b0, hdr.prev_stamp});
  assign fits = (diff[32:15] == '0) || (diff[32:15] == '1);

  always_comb begin
    res_next                      = '0;
    res_next.equihash_fields      = equi;
    res_next.kawpow_fields        = kaw;
    if (hdr.has_previous) begin
      res_next.list_pos             = hit ? 3'(hit_pos) + 3'd1 : 3'd0;
      res_next.prev_hash_compressed = 1'b1;
      res_next.time_compressed      = fits;
      res_next.stamp_delta          = fits ? diff[15:0] : 16'sd0;
      res_next.bits_compressed      = (hdr.target_bits == hdr.prev_target_bits);
    end
  end

  // list storage, no reset: entries at or beyond count are never read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      recent[0] <= hdr.version;
      for (int j = 1; j < LIST_DEPTH; j++) begin
        if (IW'(j) <= shift_lim) begin
          recent[j] <= recent[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && !hit && !status.list_full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("list count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !hdr.has_previous && !status.list_full |=> count == $past(count) + CW'(1))
    else $error("push did not grow list");
  a_front: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> recent[0] == $past(hdr.version))
    else $error("front entry is not the last version");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load) |-> !(res.kawpow_fields && res.equihash_fields))
    else $error("both algorithm flags set");
`endif

endmodule

// ===== hw/rtl/block_header_delta_compressor.sv =====
// Top level of the header delta compressor: channel wiring, controller
// and datapath. Depends on bhdc_pkg, bhdc_ifs, bhdc_ctrl, bhdc_datapath.
//
// Usage:
//   in_hdr  - header word (version, stamp, target bits, previous-header
//             fields); taken when valid and ready are high at a clock edge.
//   out_hdr - one result word per header, from an output register.
//   cfg     - register writes (index 0..3: algo mask, kawpow code, equihash
//             wide code, equihash narrow code); always ready, write only
//             while no header is in flight. Other indexes are ignored.
// Result: registered; valid the cycle after the header is accepted.
// Throughput: one header per unstalled cycle. The version compare against
//   all list entries, the move-to-front shift and the 33-bit time subtract
//   finish in the accept cycle, so the list is current for the next word.
// Stall: a held result keeps in_hdr.ready low until out_hdr.ready rises;
//   in that cycle the result leaves and the next word is taken together.
// Reset (rst, synchronous, active high): config registers return to their
//   defaults, the list empties (count 0) and no result is pending. No
//   clearing pass is needed; list entries past the count are never read.
module block_header_delta_compressor #(
  parameter int unsigned LIST_DEPTH = bhdc_pkg::DEF_LIST_DEPTH
) (
  input logic        clk,
  input logic        rst,
  bhdc_in_if.sink    in_hdr,
  bhdc_out_if.source out_hdr,
  bhdc_cfg_if.sink   cfg
);
  import bhdc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  hdr_word_t  hdr;
  res_word_t  res;

  assign hdr.version          = in_hdr.version;
  assign hdr.stamp            = in_hdr.stamp;
  assign hdr.target_bits      = in_hdr.target_bits;
  assign hdr.has_previous     = in_hdr.has_previous;
  assign hdr.prev_stamp       = in_hdr.prev_stamp;
  assign hdr.prev_target_bits = in_hdr.prev_target_bits;

  // sequencing of the result register and config writes
  bhdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_hdr.valid),
    .in_ready  (in_hdr.ready),
    .out_valid (out_hdr.valid),
    .out_ready (out_hdr.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // list, compares, time delta, result register
  bhdc_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .hdr       (hdr),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (res)
  );

  assign out_hdr.list_pos             = res.list_pos;
  assign out_hdr.prev_hash_compressed = res.prev_hash_compressed;
  assign out_hdr.time_compressed      = res.time_compressed;
  assign out_hdr.stamp_delta          = res.stamp_delta;
  assign out_hdr.bits_compressed      = res.bits_compressed;
  assign out_hdr.equihash_fields      = res.equihash_fields;
  assign out_hdr.kawpow_fields        = res.kawpow_fields;

endmodule
